// File: sv/mexp_pkg.sv
// Shared widths, datapath operation codes and controller/datapath link types.
`timescale 1ns / 1ps

package mexp_pkg;

  localparam int WIDTH     = 32;
  localparam int CNT_W     = $clog2(WIDTH);
  localparam int BIT_CNT_W = $clog2(WIDTH + 1);

  typedef enum logic [1:0] {
    OP_RED,
    OP_ACC,
    OP_SQR
  } mul_op_t;

  typedef struct packed {
    logic    load;
    logic    start;
    mul_op_t op;
    logic    e_shift;
    logic    publish;
  } mexp_cmd_t;

  typedef struct packed {
    logic busy;
    logic mul_done;
    logic e_bit;
    logic zero_mod;
  } mexp_stat_t;

endpackage

// File: sv/mexp_in_if.sv
// Operand channel: base, exponent and modulus with valid/ready.
`timescale 1ns / 1ps

interface mexp_in_if;
  import mexp_pkg::*;

  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] base_value;
  logic [WIDTH-1:0] exponent_value;
  logic [WIDTH-1:0] modulus_value;

  modport source (output valid, output base_value, output exponent_value,
                  output modulus_value, input ready);
  modport sink   (input valid, input base_value, input exponent_value,
                  input modulus_value, output ready);
endinterface

// File: sv/mexp_out_if.sv
// Result channel: power result and zero-modulus flag with valid/ready.
`timescale 1ns / 1ps

interface mexp_out_if;
  import mexp_pkg::*;

  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] power_result;
  logic             zero_modulus;

  modport source (output valid, output power_result, output zero_modulus, input ready);
  modport sink   (input valid, input power_result, input zero_modulus, output ready);
endinterface

// File: sv/mexp_datapath.sv
// Datapath: operand registers, bit-serial multiply-reduce unit, result register.
`timescale 1ns / 1ps

module mexp_datapath (
  input  logic                       clk,
  input  logic                       rst,
  input  mexp_pkg::mexp_cmd_t        cmd,
  output mexp_pkg::mexp_stat_t       stat,
  input  logic [mexp_pkg::WIDTH-1:0] base_value,
  input  logic [mexp_pkg::WIDTH-1:0] exponent_value,
  input  logic [mexp_pkg::WIDTH-1:0] modulus_value,
  output logic [mexp_pkg::WIDTH-1:0] power_result,
  output logic                       zero_modulus
);
  import mexp_pkg::*;

  logic [WIDTH-1:0] b_reg;
  logic [WIDTH-1:0] e_reg;
  logic [WIDTH-1:0] m_reg;
  logic [WIDTH-1:0] acc_reg;
  logic             zm_reg;

  // Multiply-reduce unit state
  logic [WIDTH-1:0] x_sh;
  logic [WIDTH-1:0] y_reg;
  logic [WIDTH-1:0] r;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  mul_op_t          op_reg;

  logic             last;
  logic [WIDTH:0]   t;
  logic [WIDTH-1:0] t1;
  logic [WIDTH:0]   u;
  logic [WIDTH-1:0] r_next;
  logic [WIDTH-1:0] x_start;
  logic [WIDTH-1:0] y_start;

  assign last = busy && (cnt == CNT_W'(WIDTH - 1));

  // One step of MSB-first interleaved multiply: r = (2r + xbit*y) mod m
  always_comb begin
    t  = {r, 1'b0};
    t1 = (t >= {1'b0, m_reg}) ? WIDTH'(t - {1'b0, m_reg}) : t[WIDTH-1:0];
    u  = {1'b0, t1} + (x_sh[WIDTH-1] ? {1'b0, y_reg} : '0);
    r_next = (u >= {1'b0, m_reg}) ? WIDTH'(u - {1'b0, m_reg}) : u[WIDTH-1:0];
  end

  // Operand selection; reduction multiplies the raw base by one
  always_comb begin
    unique case (cmd.op)
      OP_RED:  begin x_start = b_reg;   y_start = WIDTH'(1); end
      OP_ACC:  begin x_start = acc_reg; y_start = b_reg;     end
      OP_SQR:  begin x_start = b_reg;   y_start = b_reg;     end
      default: begin x_start = b_reg;   y_start = b_reg;     end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else begin
      if (cmd.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (last) begin
        busy <= 1'b0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
      end
    end

    if (cmd.start) begin
      x_sh   <= x_start;
      y_reg  <= y_start;
      r      <= '0;
      op_reg <= cmd.op;
    end else if (busy) begin
      x_sh <= {x_sh[WIDTH-2:0], 1'b0};
      r    <= r_next;
    end

    if (cmd.load) begin
      b_reg   <= base_value;
      e_reg   <= exponent_value;
      m_reg   <= modulus_value;
      zm_reg  <= (modulus_value == '0);
      acc_reg <= (modulus_value == WIDTH'(1)) ? '0 : WIDTH'(1);
    end else begin
      if (last) begin
        if (op_reg == OP_ACC) acc_reg <= r_next;
        else                  b_reg   <= r_next;
      end
      if (cmd.e_shift) e_reg <= {1'b0, e_reg[WIDTH-1:1]};
    end

    if (cmd.publish) begin
      power_result <= zm_reg ? '0 : acc_reg;
      zero_modulus <= zm_reg;
    end
  end

  assign stat.busy     = busy;
  assign stat.mul_done = last;
  assign stat.e_bit    = e_reg[0];
  assign stat.zero_mod = zm_reg;

  a_partial_below_mod: assert property (@(posedge clk) disable iff (rst)
    (busy && !cmd.start) |=> (r < m_reg) || $past(last))
    else $error("partial remainder left the modulus range");

  a_start_runs: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> busy && (cnt == '0))
    else $error("multiply-reduce unit did not start");

endmodule

// File: sv/mexp_ctrl.sv
// Controller: sequences reduction, multiply and square passes over the exponent bits.
`timescale 1ns / 1ps

module mexp_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output mexp_pkg::mexp_cmd_t   cmd,
  input  mexp_pkg::mexp_stat_t  stat
);
  import mexp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_RED,
    S_BIT,
    S_ACC,
    S_SQR,
    S_DONE
  } state_t;

  state_t               state;
  state_t               state_next;
  logic [BIT_CNT_W-1:0] bit_cnt;
  logic                 can_publish;

  assign in_ready    = (state == S_IDLE);
  assign can_publish = !out_valid || out_ready;

  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.op      = OP_RED;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.zero_mod) begin
          state_next = S_DONE;
        end else begin
          cmd.start  = 1'b1;
          cmd.op     = OP_RED;
          state_next = S_RED;
        end
      end
      S_RED: begin
        if (stat.mul_done) state_next = S_BIT;
      end
      S_BIT: begin
        if (bit_cnt == BIT_CNT_W'(WIDTH)) begin
          state_next = S_DONE;
        end else begin
          cmd.start  = 1'b1;
          cmd.op     = stat.e_bit ? OP_ACC : OP_SQR;
          state_next = stat.e_bit ? S_ACC : S_SQR;
        end
      end
      S_ACC: begin
        if (stat.mul_done) begin
          cmd.start  = 1'b1;
          cmd.op     = OP_SQR;
          state_next = S_SQR;
        end
      end
      S_SQR: begin
        if (stat.mul_done) begin
          cmd.e_shift = 1'b1;
          state_next  = S_BIT;
        end
      end
      S_DONE: begin
        if (can_publish) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      bit_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load)         bit_cnt <= '0;
      else if (cmd.e_shift) bit_cnt <= bit_cnt + BIT_CNT_W'(1);
      if (cmd.publish)      out_valid <= 1'b1;
      else if (out_ready)   out_valid <= 1'b0;
    end
  end

  a_start_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.start |-> (!stat.busy || stat.mul_done))
    else $error("multiply-reduce unit restarted while busy");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |-> (!out_valid || out_ready))
    else $error("pending result overwritten");

  a_unit_idles: assert property (@(posedge clk) disable iff (rst)
    (stat.mul_done && !cmd.start) |=> !stat.busy)
    else $error("multiply-reduce unit kept running after its last step");

endmodule

// File: sv/modular_exponentiation_unit.sv
// Top level: modular exponentiation by right-to-left square-and-multiply.
//
//   channel    role    payload
//   operands   sink    base_value, exponent_value, modulus_value
//   results    source  power_result, zero_modulus
//
// A zero modulus skips the reduction and the exponent loop. The bit-serial
// multiply-reduce unit computes one product bit per cycle and is shared by the
// reduction, square and multiply passes.
// Reset (rst, synchronous) returns the controller to idle and drops a pending result.
// Input is taken only in idle, so operands wait until the prior result is published; a result
// still parked when the next one finishes holds the controller and therefore the input.
`timescale 1ns / 1ps

module modular_exponentiation_unit (
  input logic       clk,
  input logic       rst,
  mexp_in_if.sink   operands,
  mexp_out_if.source results
);
  import mexp_pkg::*;

  mexp_cmd_t  cmd;
  mexp_stat_t stat;

  // Sequencer: accept, reduce the base, walk the exponent bits, publish
  mexp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (operands.valid),
    .in_ready  (operands.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Operand registers, multiply-reduce unit and output register
  mexp_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .base_value     (operands.base_value),
    .exponent_value (operands.exponent_value),
    .modulus_value  (operands.modulus_value),
    .power_result   (results.power_result),
    .zero_modulus   (results.zero_modulus)
  );

endmodule

// File: dv/modular_exponentiation_unit_tb.sv
// Self-checking testbench for the modular exponentiation unit.
`timescale 1ns / 1ps

module modular_exponentiation_unit_tb;
  import mexp_pkg::*;

  // Longer than the slowest transaction, with a little margin.
  localparam int DRAIN_CYCLES = 2300;
  // Roughly 300 transactions run in all; keep the limit several times above
  // their total at worst-case latency.
  localparam int CYCLE_LIMIT  = 4_000_000;
  localparam int PHASE_ITEMS  = 64;
  localparam logic [WIDTH-1:0] ALL_ONES = {WIDTH{1'b1}};

  typedef struct packed {
    logic [WIDTH-1:0] power_result;
    logic             zero_modulus;
  } power_t;

  logic clk;
  logic rst;

  mexp_in_if  operands_if ();
  mexp_out_if results_if ();

  modular_exponentiation_unit dut (
    .clk      (clk),
    .rst      (rst),
    .operands (operands_if),
    .results  (results_if)
  );

  // Powers still owed by the block, oldest first.
  power_t pending_powers[$];
  int     mismatch_count = 0;
  int     cycle_count    = 0;

  // Idle percentages of the current phase (0 means never idle).
  int     send_idle_pct  = 0;
  int     recv_stall_pct = 0;

  // A hold-off is requested by bumping the sequence number; the result-side
  // process then keeps ready low on its own for the length given by hold_off_len.
  int     hold_off_len   = 0;
  int     hold_off_seq   = 0;
  int     hold_off_seen  = 0;
  int     hold_off_left  = 0;

  initial begin
    clk = 1'b0;
  end

  always #1 clk = ~clk;

  // Square-and-multiply from bit 0 upward. Every value stays below the modulus,
  // so each product fits in 2*WIDTH bits.
  function automatic power_t predict_power(logic [WIDTH-1:0] base_in,
                                           logic [WIDTH-1:0] exp_in,
                                           logic [WIDTH-1:0] mod_in);
    power_t             res;
    logic [2*WIDTH-1:0] mod_w;
    logic [2*WIDTH-1:0] sq;
    logic [2*WIDTH-1:0] acc;
    res.zero_modulus = (mod_in == '0);
    res.power_result = '0;
    if (mod_in == '0) begin
      return res;
    end
    mod_w = {{WIDTH{1'b0}}, mod_in};
    sq    = {{WIDTH{1'b0}}, base_in};
    sq    = sq % mod_w;
    acc   = {{(2*WIDTH-1){1'b0}}, 1'b1};
    acc   = acc % mod_w;
    for (int i = 0; i < WIDTH; i++) begin
      if (exp_in[i]) begin
        acc = (acc * sq) % mod_w;
      end
      sq = (sq * sq) % mod_w;
    end
    res.power_result = acc[WIDTH-1:0];
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // Offer one operand set and return at the edge where it is taken. Valid stays
  // high on return, so back-to-back calls keep the channel busy without a bubble.
  task automatic send_operands(input logic [WIDTH-1:0] base_in,
                               input logic [WIDTH-1:0] exp_in,
                               input logic [WIDTH-1:0] mod_in);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      operands_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    operands_if.valid          <= 1'b1;
    operands_if.base_value     <= base_in;
    operands_if.exponent_value <= exp_in;
    operands_if.modulus_value  <= mod_in;
    @(posedge clk);
    while (!operands_if.ready) @(posedge clk);
    pending_powers.insert(pending_powers.size(), predict_power(base_in, exp_in, mod_in));
  endtask

  // Drop valid right at the acceptance edge so nothing is taken twice.
  task automatic hold_operands();
    operands_if.valid <= 1'b0;
  endtask

  task automatic wait_for_results();
    while (pending_powers.size() != 0) @(posedge clk);
  endtask

  // Pick operands that lean toward the interesting corners: zero and unit moduli,
  // small moduli, moduli near the top, bases at or around the modulus, and
  // exponents that are zero, short or all ones. The rest is full-range noise.
  task automatic random_operands(output logic [WIDTH-1:0] base_out,
                                 output logic [WIDTH-1:0] exp_out,
                                 output logic [WIDTH-1:0] mod_out);
    int pick;
    pick = $urandom_range(99);
    if (pick < 8)       mod_out = '0;
    else if (pick < 13) mod_out = 1;
    else if (pick < 35) mod_out = $urandom_range(255, 2);
    else if (pick < 45) mod_out = ALL_ONES - $urandom_range(15);
    else                mod_out = $urandom;
    pick = $urandom_range(99);
    if (pick < 10)      base_out = '0;
    else if (pick < 15) base_out = 1;
    else if (pick < 25) base_out = mod_out - 1;
    else if (pick < 35) base_out = mod_out;
    else                base_out = $urandom;
    pick = $urandom_range(99);
    if (pick < 8)       exp_out = '0;
    else if (pick < 15) exp_out = $urandom_range(31);
    else if (pick < 22) exp_out = ALL_ONES;
    else                exp_out = $urandom;
  endtask

  // Corners: zero modulus, unit modulus, zero exponent, zero base, full-scale
  // fields, a base that needs reducing, and a few primes.
  task automatic test_directed_corners();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_operands('0, '0, '0);
    send_operands(ALL_ONES, ALL_ONES, '0);
    send_operands(5, '0, 7);
    send_operands(5, '0, 1);
    send_operands(ALL_ONES, ALL_ONES, 1);
    send_operands('0, '0, 5);
    send_operands('0, ALL_ONES, ALL_ONES);
    send_operands(ALL_ONES, ALL_ONES, ALL_ONES);
    send_operands(ALL_ONES - 1, ALL_ONES, ALL_ONES);
    send_operands(2, 31, ALL_ONES);
    send_operands(3, ALL_ONES, 2);
    send_operands(ALL_ONES, 1, 13);
    send_operands(7, 1, ALL_ONES);
    send_operands(32'd12345678, 32'd87654321, 32'hFFFF_FFFB);
    send_operands(2, 32'h8000_0000, 32'd1000000007);
    send_operands(ALL_ONES, 2, ALL_ONES - 1);
    send_operands(1, ALL_ONES, ALL_ONES);
    send_operands(32'h8000_0000, 32'hAAAA_AAAA, 32'h8000_0001);
    send_operands(32'h0001_2345, 32'h5555_5555, 32'hFFFF_0001);
    hold_operands();
    wait_for_results();
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct);
    logic [WIDTH-1:0] b;
    logic [WIDTH-1:0] e;
    logic [WIDTH-1:0] m;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (PHASE_ITEMS) begin
      random_operands(b, e, m);
      send_operands(b, e, m);
    end
    hold_operands();
    wait_for_results();
  endtask

  // Hold the result side off long enough for one result to park in the output
  // register and a second to finish computing; the input must then stall.
  task automatic test_output_backpressure();
    logic [WIDTH-1:0] b;
    logic [WIDTH-1:0] e;
    logic [WIDTH-1:0] m;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_len   = 4 * DRAIN_CYCLES;
    hold_off_seq++;
    repeat (6) begin
      random_operands(b, e, m);
      send_operands(b, e, m);
    end
    hold_operands();
    wait_for_results();
  endtask

  // Let the block go fully idle between transactions, then pick up again.
  task automatic test_drain_and_resume();
    logic [WIDTH-1:0] b;
    logic [WIDTH-1:0] e;
    logic [WIDTH-1:0] m;
    send_idle_pct  = 0;
    recv_stall_pct = 46;
    repeat (4) begin
      random_operands(b, e, m);
      send_operands(b, e, m);
      hold_operands();
      wait_for_results();
      repeat ($urandom_range(5)) @(posedge clk);
    end
  endtask

  // Result side: honor a requested hold-off, otherwise stall at the phase's rate.
  always @(posedge clk) begin
    if (hold_off_seen != hold_off_seq) begin
      hold_off_seen     = hold_off_seq;
      hold_off_left     = hold_off_len;
    end
    if (hold_off_left > 0) begin
      hold_off_left--;
      results_if.ready <= 1'b0;
    end else begin
      results_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare every delivered result against the oldest prediction.
  always @(posedge clk) begin
    power_t want;
    if (!rst && results_if.valid && results_if.ready) begin
      if (pending_powers.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: power=%h zero_mod=%b",
                                  results_if.power_result, results_if.zero_modulus));
      end else begin
        want = pending_powers.pop_front();
        if (results_if.power_result !== want.power_result) begin
          report_mismatch($sformatf("power_result got %h want %h",
                                    results_if.power_result, want.power_result));
        end
        if (results_if.zero_modulus !== want.zero_modulus) begin
          report_mismatch($sformatf("zero_modulus got %b want %b",
                                    results_if.zero_modulus, want.zero_modulus));
        end
      end
    end
  end

  // Watchdog: a hang or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_powers.size());
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    rst                        = 1'b1;
    operands_if.valid          = 1'b0;
    operands_if.base_value     = '0;
    operands_if.exponent_value = '0;
    operands_if.modulus_value  = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_corners();
    // Idle phases: none, sender only, receiver only, both.
    test_random_traffic(0, 0);
    test_random_traffic(46, 0);
    test_random_traffic(0, 46);
    test_random_traffic(38, 38);
    test_output_backpressure();
    test_drain_and_resume();

    // Watch a little longer for any stray result.
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_powers.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/mexp_pkg.sv
sv/mexp_in_if.sv
sv/mexp_out_if.sv
sv/mexp_datapath.sv
sv/mexp_ctrl.sv
sv/modular_exponentiation_unit.sv
dv/modular_exponentiation_unit_tb.sv
